// ===== hw/rtl/tcl_pkg.sv =====
// Shared types and constants of the three-level tag lookup.
`timescale 1ns / 1ps
package tcl_pkg;

	localparam int ADDR_W    = 32;
	localparam int STAMP_W   = 32;
	localparam int LINE_BITS = 6;
	localparam int LINE_W    = ADDR_W - LINE_BITS;

	localparam int DEF_L1_SETS = 64;
	localparam int DEF_L1_WAYS = 4;
	localparam int DEF_L2_SETS = 256;
	localparam int DEF_L2_WAYS = 8;
	localparam int DEF_L3_SETS = 1024;
	localparam int DEF_L3_WAYS = 16;

	localparam logic [1:0] LVL_NONE = 2'd3;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_SCAN,
		ST_WRITE,
		ST_RESP
	} state_t;

	// commands from the sequencer to one level
	typedef struct packed {
		logic rd;
		logic scan_start;
		logic scan_step;
		logic wr_fill;
		logic wr_touch;
	} ctrl_t;

	// status from one level back to the sequencer
	typedef struct packed {
		logic clr_done;
		logic scan_done;
		logic hit;
	} status_t;

endpackage

// ===== hw/rtl/tcl_level.sv =====
// One cache level: set memory, way scan, hit refresh and LRU fill.
`timescale 1ns / 1ps
module tcl_level #(
	parameter int SETS = tcl_pkg::DEF_L1_SETS,
	parameter int WAYS = tcl_pkg::DEF_L1_WAYS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tcl_pkg::ctrl_t               ctrl,
	input  logic [tcl_pkg::ADDR_W-1:0]   address,
	input  logic [tcl_pkg::STAMP_W-1:0]  stamp,
	output tcl_pkg::status_t             status
);
	import tcl_pkg::*;

	localparam int IW  = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int CNW = $clog2(SETS + 1);
	localparam int TW  = $clog2(((2 ** LINE_W) - 1) / SETS + 1);
	localparam int WW  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int CW  = $clog2(WAYS + 1);

	logic [LINE_W-1:0] line;
	logic [IW-1:0]     set_idx;
	logic [TW-1:0]     tag;

	logic [WAYS-1:0]              vld_mem [SETS];
	logic [WAYS-1:0][TW-1:0]      tag_mem [SETS];
	logic [WAYS-1:0][STAMP_W-1:0] stp_mem [SETS];

	logic [WAYS-1:0]              vld_rd_q;
	logic [WAYS-1:0][TW-1:0]      tag_rd_q;
	logic [WAYS-1:0][STAMP_W-1:0] stp_rd_q;

	logic [WAYS-1:0]              vld_new;
	logic [WAYS-1:0][TW-1:0]      tag_new;
	logic [WAYS-1:0][STAMP_W-1:0] stp_new;

	logic [CNW-1:0] clr_cnt_q;
	logic           clr_busy;

	logic [CW-1:0]      way_q;
	logic [WW-1:0]      way;
	logic               scan_done;
	logic               hit_q;
	logic [WW-1:0]      hit_way_q;
	logic               free_q;
	logic [WW-1:0]      free_way_q;
	logic [WW-1:0]      min_way_q;
	logic [STAMP_W-1:0] min_stp_q;
	logic [WW-1:0]      victim;

	// split the line number into set index and tag
	assign line    = address[ADDR_W-1:LINE_BITS];
	assign set_idx = IW'(line % SETS);
	assign tag     = TW'(line / SETS);

	// sweep the valid bits after reset
	assign clr_busy = (clr_cnt_q != CNW'(SETS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (clr_busy) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// set memory: one row write, one registered row read
	always_ff @(posedge clk) begin
		if (clr_busy) begin
			vld_mem[clr_cnt_q[IW-1:0]] <= '0;
		end else if (ctrl.wr_fill || ctrl.wr_touch) begin
			vld_mem[set_idx] <= vld_new;
			tag_mem[set_idx] <= tag_new;
			stp_mem[set_idx] <= stp_new;
		end
		if (ctrl.rd) begin
			vld_rd_q <= vld_mem[set_idx];
			tag_rd_q <= tag_mem[set_idx];
			stp_rd_q <= stp_mem[set_idx];
		end
	end

	// scan one way per cycle: match, first free way, oldest stamp
	assign way       = way_q[WW-1:0];
	assign scan_done = (way_q == CW'(WAYS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			way_q  <= '0;
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (ctrl.scan_start) begin
			way_q  <= '0;
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (ctrl.scan_step && !scan_done) begin
			way_q <= way_q + 1'b1;
			if (vld_rd_q[way] && tag_rd_q[way] == tag && !hit_q) begin
				hit_q <= 1'b1;
			end
			if (!vld_rd_q[way] && !free_q) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.scan_step && !scan_done) begin
			if (vld_rd_q[way] && tag_rd_q[way] == tag && !hit_q) begin
				hit_way_q <= way;
			end
			if (!vld_rd_q[way] && !free_q) begin
				free_way_q <= way;
			end
			if (way_q == '0 || stp_rd_q[way] < min_stp_q) begin
				min_stp_q <= stp_rd_q[way];
				min_way_q <= way;
			end
		end
	end

	// build the updated row: refresh the hit way or fill the victim
	assign victim = free_q ? free_way_q : min_way_q;

	always_comb begin
		vld_new = vld_rd_q;
		tag_new = tag_rd_q;
		stp_new = stp_rd_q;
		if (ctrl.wr_touch) begin
			stp_new[hit_way_q] = stamp;
		end else begin
			vld_new[victim] = 1'b1;
			tag_new[victim] = tag;
			stp_new[victim] = stamp;
		end
	end

	assign status.clr_done  = !clr_busy;
	assign status.scan_done = scan_done;
	assign status.hit       = hit_q;

endmodule

// ===== hw/rtl/three_level_cache_tag_lookup_lru.sv =====
// Sequence: a request accepted in IDLE passes READ, SCAN, WRITE and RESP; RESP
// waits while rsp_stall holds a pending result. One request at a time; the way
// scan steps through the set rows read from the three level memories.
// Reset: asynchronous; after it a clearing pass sweeps the valid bits with
// req_stall high.
`timescale 1ns / 1ps
module three_level_cache_tag_lookup_lru #(
	parameter int L1_SETS = tcl_pkg::DEF_L1_SETS,
	parameter int L1_WAYS = tcl_pkg::DEF_L1_WAYS,
	parameter int L2_SETS = tcl_pkg::DEF_L2_SETS,
	parameter int L2_WAYS = tcl_pkg::DEF_L2_WAYS,
	parameter int L3_SETS = tcl_pkg::DEF_L3_SETS,
	parameter int L3_WAYS = tcl_pkg::DEF_L3_WAYS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic [tcl_pkg::ADDR_W-1:0]   address,
	input  logic [tcl_pkg::STAMP_W-1:0]  stamp,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic                         hit,
	output logic [1:0]                   hit_level
);
	import tcl_pkg::*;

	state_t state_q, state_nxt;

	logic [ADDR_W-1:0]  addr_q;
	logic [STAMP_W-1:0] stamp_q;
	ctrl_t              ctrl1, ctrl2, ctrl3;
	status_t            stat1, stat2, stat3;
	logic [1:0]         lvl;
	logic               accept;
	logic               load_rsp;
	logic               rsp_valid_q;
	logic               hit_q;
	logic [1:0]         hit_level_q;

	tcl_level #(.SETS(L1_SETS), .WAYS(L1_WAYS)) u_l1 (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl1),
		.address(addr_q), .stamp(stamp_q), .status(stat1)
	);
	tcl_level #(.SETS(L2_SETS), .WAYS(L2_WAYS)) u_l2 (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl2),
		.address(addr_q), .stamp(stamp_q), .status(stat2)
	);
	tcl_level #(.SETS(L3_SETS), .WAYS(L3_WAYS)) u_l3 (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl3),
		.address(addr_q), .stamp(stamp_q), .status(stat3)
	);

	// first level that hit
	always_comb begin
		if (stat1.hit) begin
			lvl = 2'd0;
		end else if (stat2.hit) begin
			lvl = 2'd1;
		end else if (stat3.hit) begin
			lvl = 2'd2;
		end else begin
			lvl = LVL_NONE;
		end
	end

	assign accept   = req_valid && !req_stall;
	assign load_rsp = (state_q == ST_RESP) && (!rsp_valid_q || !rsp_stall);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (stat1.clr_done && stat2.clr_done && stat3.clr_done) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_nxt = ST_READ;
				end
			end
			ST_READ: state_nxt = ST_SCAN;
			ST_SCAN: begin
				if (stat1.scan_done && stat2.scan_done && stat3.scan_done) begin
					state_nxt = ST_WRITE;
				end
			end
			ST_WRITE: state_nxt = ST_RESP;
			ST_RESP: begin
				if (load_rsp) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_CLEAR;
		endcase
	end

	// level commands
	always_comb begin
		ctrl1     = '0;
		ctrl2     = '0;
		ctrl3     = '0;
		req_stall = 1'b1;
		case (state_q)
			ST_IDLE: req_stall = 1'b0;
			ST_READ: begin
				ctrl1.rd = 1'b1; ctrl1.scan_start = 1'b1;
				ctrl2.rd = 1'b1; ctrl2.scan_start = 1'b1;
				ctrl3.rd = 1'b1; ctrl3.scan_start = 1'b1;
			end
			ST_SCAN: begin
				ctrl1.scan_step = 1'b1;
				ctrl2.scan_step = 1'b1;
				ctrl3.scan_step = 1'b1;
			end
			ST_WRITE: begin
				ctrl1.wr_touch = (lvl == 2'd0);
				ctrl1.wr_fill  = (lvl != 2'd0);
				ctrl2.wr_touch = (lvl == 2'd1);
				ctrl2.wr_fill  = (lvl == 2'd2) || (lvl == LVL_NONE);
				ctrl3.wr_touch = (lvl == 2'd2);
				ctrl3.wr_fill  = (lvl == LVL_NONE);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// hold the request
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q  <= address;
			stamp_q <= stamp;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			hit_q       <= (lvl != LVL_NONE);
			hit_level_q <= lvl;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign hit       = hit_q;
	assign hit_level = hit_level_q;

endmodule
